// File: sv/pibb_pkg.sv
`default_nettype none
package pibb_pkg;

  // width of one packed pixel color
  localparam int unsigned ColorBits = 32;
  // width of the palette index on the result channel
  localparam int unsigned IndexBits = 8;
  // width of the configured row length
  localparam int unsigned WidthBits = 13;
  // width of each box coordinate on the result channel
  localparam int unsigned BoxOutBits = 12;
  // image width after reset
  localparam logic [WidthBits-1:0] WidthReset = 13'd1024;

  // control flags that travel with a pixel from cell to cell
  typedef struct packed {
    logic vld;    // stage holds a pixel
    logic start;  // pixel opens a frame
    logic found;  // some cell matched or took the color
    logic fresh;  // some cell took the color as a new entry
  } pibb_ctl_t;

endpackage
`default_nettype wire

// File: sv/palette_index_with_bounding_boxes_core.sv
// Palette indexer with per-color bounding boxes.
// in_*  : one pixel per transfer; in_tdata is the 32-bit color, in_tuser
//         marks the first pixel of a frame (palette and x/y restart there).
// cfg_* : writes image_width (pixels per row); write only while idle.
// out_* : one result per pixel: palette index, box of that index, and
//         flags in out_tuser (new entry, palette full).
// The palette is a row of PALETTE_DEPTH cells, one entry each. A pixel
// walks the row one cell per cycle while the row advances and leaves it
// through the last cell stage, which is the output register. One pixel per
// cycle is taken while the receiver keeps up.
// The whole row advances on one enable: when a result sits in the output
// register and out_tready is low, the row holds and in_tready goes low.
// Empty stages move along with the row and do not stop the input.
// Reset empties the palette, clears x/y and sets the width to 1024; no
// clearing pass is needed, so the first pixel can follow right away.
`default_nettype none
module palette_index_with_bounding_boxes_core #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned COORD_BITS    = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] pixel_color
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [7:0] palette_index, [19:8] box_min_x,
                                       // [31:20] box_min_y, [43:32] box_max_x,
                                       // [55:44] box_max_y
  output logic [1:0]       out_tuser,  // [0] is_new_color, [1] palette_overflow
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data    // [12:0] image_width
);
  import pibb_pkg::*;

  localparam int unsigned D  = PALETTE_DEPTH;
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CW = CB + BoxOutBits;

  logic                 adv, accept;
  logic [WidthBits-1:0] width_r;
  logic [CB-1:0]        pos_x, pos_y;

  // chain links, link i feeds cell i
  pibb_ctl_t            ctl_c   [0:D];
  logic [ColorBits-1:0] color_c [0:D];
  logic [CB-1:0]        x_c     [0:D];
  logic [CB-1:0]        y_c     [0:D];
  logic [IndexBits-1:0] idx_c   [0:D];
  logic [CB-1:0]        minx_c  [0:D];
  logic [CB-1:0]        miny_c  [0:D];
  logic [CB-1:0]        maxx_c  [0:D];
  logic [CB-1:0]        maxy_c  [0:D];

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WidthReset;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  // row enable: move unless a result is held back
  assign adv       = out_tready || !ctl_c[D].vld;
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;

  pibb_coord #(.CB(CB)) u_coord (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .start (in_tuser),
    .width (width_r),
    .x_o   (pos_x),
    .y_o   (pos_y)
  );

  // head of the chain
  assign ctl_c[0].vld   = accept;
  assign ctl_c[0].start = in_tuser;
  assign ctl_c[0].found = 1'b0;
  assign ctl_c[0].fresh = 1'b0;
  assign color_c[0]     = in_tdata;
  assign x_c[0]         = pos_x;
  assign y_c[0]         = pos_y;
  assign idx_c[0]       = '0;
  assign minx_c[0]      = '0;
  assign miny_c[0]      = '0;
  assign maxx_c[0]      = '0;
  assign maxy_c[0]      = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    pibb_cell #(.CB(CB), .IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .ctl_i   (ctl_c[i]),
      .color_i (color_c[i]),
      .x_i     (x_c[i]),
      .y_i     (y_c[i]),
      .idx_i   (idx_c[i]),
      .min_x_i (minx_c[i]),
      .min_y_i (miny_c[i]),
      .max_x_i (maxx_c[i]),
      .max_y_i (maxy_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .color_o (color_c[i+1]),
      .x_o     (x_c[i+1]),
      .y_o     (y_c[i+1]),
      .idx_o   (idx_c[i+1]),
      .min_x_o (minx_c[i+1]),
      .min_y_o (miny_c[i+1]),
      .max_x_o (maxx_c[i+1]),
      .max_y_o (maxy_c[i+1])
    );
  end

  // result fields: coordinates cut or padded to 12 bits
  logic [CW-1:0] ominx, ominy, omaxx, omaxy;
  assign ominx = {{BoxOutBits{1'b0}}, minx_c[D]};
  assign ominy = {{BoxOutBits{1'b0}}, miny_c[D]};
  assign omaxx = {{BoxOutBits{1'b0}}, maxx_c[D]};
  assign omaxy = {{BoxOutBits{1'b0}}, maxy_c[D]};

  assign out_tvalid = ctl_c[D].vld;
  assign out_tdata  = {omaxy[BoxOutBits-1:0], omaxx[BoxOutBits-1:0],
                       ominy[BoxOutBits-1:0], ominx[BoxOutBits-1:0], idx_c[D]};
  assign out_tuser  = {!ctl_c[D].found, ctl_c[D].fresh};

  // a result is either new, overflow, or neither
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("new and overflow flags both set");

  // overflow carries index and box of zero
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0))
    else $error("overflow result with nonzero fields");

  // a new entry has a single-point box
  a_new_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[19:8] == out_tdata[43:32] && out_tdata[31:20] == out_tdata[55:44]))
    else $error("new entry box is not a single point");

  // a matched box is well ordered
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |->
      (minx_c[D] <= maxx_c[D] && miny_c[D] <= maxy_c[D]))
    else $error("box minimum above maximum");

endmodule
`default_nettype wire

// File: sv/pibb_cell.sv
`default_nettype none
module pibb_cell #(
  parameter int unsigned CB  = 12,
  parameter int unsigned IDX = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire pibb_pkg::pibb_ctl_t                ctl_i,
  input  wire logic [pibb_pkg::ColorBits-1:0]     color_i,
  input  wire logic [CB-1:0]                      x_i,
  input  wire logic [CB-1:0]                      y_i,
  input  wire logic [pibb_pkg::IndexBits-1:0]     idx_i,
  input  wire logic [CB-1:0]                      min_x_i,
  input  wire logic [CB-1:0]                      min_y_i,
  input  wire logic [CB-1:0]                      max_x_i,
  input  wire logic [CB-1:0]                      max_y_i,
  output pibb_pkg::pibb_ctl_t                     ctl_o,
  output logic [pibb_pkg::ColorBits-1:0]          color_o,
  output logic [CB-1:0]                           x_o,
  output logic [CB-1:0]                           y_o,
  output logic [pibb_pkg::IndexBits-1:0]          idx_o,
  output logic [CB-1:0]                           min_x_o,
  output logic [CB-1:0]                           min_y_o,
  output logic [CB-1:0]                           max_x_o,
  output logic [CB-1:0]                           max_y_o
);
  import pibb_pkg::*;

  localparam logic [IndexBits-1:0] CellIdx = IndexBits'(IDX);

  // palette entry held by this cell
  logic                 valid_r, valid_nxt;
  logic [ColorBits-1:0] color_r;
  logic [CB-1:0]        min_x_r, min_y_r, max_x_r, max_y_r;

  // pipeline stage toward the next cell
  pibb_ctl_t            ctl_r;
  logic [ColorBits-1:0] pix_r;
  logic [CB-1:0]        x_r, y_r;
  logic [IndexBits-1:0] idx_r;
  logic [CB-1:0]        bmin_x_r, bmin_y_r, bmax_x_r, bmax_y_r;

  logic          live, entry_ok, hit, claim;
  logic [CB-1:0] umin_x, umin_y, umax_x, umax_y;

  // a frame start empties the entry before the compare
  assign live     = ctl_i.vld;
  assign entry_ok = valid_r && !ctl_i.start;
  assign hit      = live && !ctl_i.found && entry_ok && (color_r == color_i);
  assign claim    = live && !ctl_i.found && !entry_ok;

  // box grown by the current coordinate
  assign umin_x = (x_i < min_x_r) ? x_i : min_x_r;
  assign umin_y = (y_i < min_y_r) ? y_i : min_y_r;
  assign umax_x = (x_i > max_x_r) ? x_i : max_x_r;
  assign umax_y = (y_i > max_y_r) ? y_i : max_y_r;

  always_comb begin
    valid_nxt = valid_r;
    if (en && live) begin
      valid_nxt = entry_ok || claim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (en && claim) begin
      color_r <= color_i;
      min_x_r <= x_i;
      min_y_r <= y_i;
      max_x_r <= x_i;
      max_y_r <= y_i;
    end else if (en && hit) begin
      min_x_r <= umin_x;
      min_y_r <= umin_y;
      max_x_r <= umax_x;
      max_y_r <= umax_y;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r.vld   <= ctl_i.vld;
      ctl_r.start <= ctl_i.start;
      ctl_r.found <= ctl_i.found || hit || claim;
      ctl_r.fresh <= ctl_i.fresh || claim;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= color_i;
      x_r   <= x_i;
      y_r   <= y_i;
      if (hit || claim) begin
        idx_r <= CellIdx;
      end else begin
        idx_r <= idx_i;
      end
      if (hit) begin
        bmin_x_r <= umin_x;
        bmin_y_r <= umin_y;
        bmax_x_r <= umax_x;
        bmax_y_r <= umax_y;
      end else if (claim) begin
        bmin_x_r <= x_i;
        bmin_y_r <= y_i;
        bmax_x_r <= x_i;
        bmax_y_r <= y_i;
      end else begin
        bmin_x_r <= min_x_i;
        bmin_y_r <= min_y_i;
        bmax_x_r <= max_x_i;
        bmax_y_r <= max_y_i;
      end
    end
  end

  assign ctl_o   = ctl_r;
  assign color_o = pix_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign idx_o   = idx_r;
  assign min_x_o = bmin_x_r;
  assign min_y_o = bmin_y_r;
  assign max_x_o = bmax_x_r;
  assign max_y_o = bmax_y_r;

endmodule
`default_nettype wire

// File: sv/pibb_coord.sv
`default_nettype none
module pibb_coord #(
  parameter int unsigned CB = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            start,
  input  wire logic [pibb_pkg::WidthBits-1:0]  width,
  output logic [CB-1:0]                        x_o,
  output logic [CB-1:0]                        y_o
);
  import pibb_pkg::*;

  // wide enough for the width register and for a full row of 2^CB
  localparam int unsigned LW = (CB + 1 > WidthBits) ? CB + 1 : WidthBits;

  logic [CB-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [LW-1:0] w_ext, limit, row_len, step;

  // position of the pixel being taken in
  assign x_o = start ? '0 : col_r;
  assign y_o = start ? '0 : row_r;

  // row length: zero acts as one, clamp at 2^CB
  assign w_ext = LW'(width);
  assign limit = LW'(1) << CB;
  always_comb begin
    if (w_ext == '0) begin
      row_len = LW'(1);
    end else if (w_ext > limit) begin
      row_len = limit;
    end else begin
      row_len = w_ext;
    end
  end

  // raster step
  assign step = LW'(x_o) + LW'(1);
  always_comb begin
    if (step >= row_len) begin
      col_nxt = '0;
      row_nxt = y_o + CB'(1);
    end else begin
      col_nxt = step[CB-1:0];
      row_nxt = y_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (en) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// File: tb/pibb_checker.sv
`timescale 1ns / 100ps
module pibb_checker #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] pixel_color
  input  wire logic        in_tuser,   // [0] frame_start
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [55:0] out_tdata,  // [7:0] palette_index, [19:8] box_min_x,
                                       // [31:20] box_min_y, [43:32] box_max_x,
                                       // [55:44] box_max_y
  input  wire logic [1:0]  out_tuser,  // [0] is_new_color, [1] palette_overflow
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [12:0] cfg_data,   // [12:0] image_width
  output int               mismatches,
  output int               pending,
  output int               checked,
  output int               fresh_entries,
  output int               overflows,
  output int               widths_written
);
  import pibb_pkg::*;

  // one result transfer, split into its fields
  typedef struct packed {
    logic [IndexBits-1:0]  index;
    logic                  fresh;
    logic                  full;
    logic [BoxOutBits-1:0] min_x;
    logic [BoxOutBits-1:0] min_y;
    logic [BoxOutBits-1:0] max_x;
    logic [BoxOutBits-1:0] max_y;
  } pixel_result_t;

  // palette and box state as the block should hold it
  logic [ColorBits-1:0]  palette_colors [PALETTE_DEPTH];
  logic [BoxOutBits-1:0] low_x  [PALETTE_DEPTH];
  logic [BoxOutBits-1:0] low_y  [PALETTE_DEPTH];
  logic [BoxOutBits-1:0] high_x [PALETTE_DEPTH];
  logic [BoxOutBits-1:0] high_y [PALETTE_DEPTH];
  int unsigned           palette_used;
  logic [BoxOutBits-1:0] column;
  logic [BoxOutBits-1:0] row;
  logic [WidthBits-1:0]  row_width;

  pixel_result_t queued_pixel_results [$];
  pixel_result_t want;
  pixel_result_t got;

  // look one pixel up, update palette and boxes, step x/y
  function automatic pixel_result_t classify_pixel(logic [31:0] color, logic start);
    pixel_result_t r;
    int unsigned   slot;
    int unsigned   k;
    bit            hit;
    logic [12:0]   span;
    logic [12:0]   next_col;
    r    = '0;
    hit  = 1'b0;
    slot = 0;
    if (start) begin
      palette_used = 0;
      column       = '0;
      row          = '0;
    end
    for (k = 0; k < palette_used; k++) begin
      if (!hit && palette_colors[k] == color) begin
        hit  = 1'b1;
        slot = k;
      end
    end
    if (hit) begin
      if (column < low_x[slot])  low_x[slot]  = column;
      if (row    < low_y[slot])  low_y[slot]  = row;
      if (column > high_x[slot]) high_x[slot] = column;
      if (row    > high_y[slot]) high_y[slot] = row;
    end else if (palette_used < PALETTE_DEPTH) begin
      // unseen color takes the next entry, box starts at this pixel
      slot                 = palette_used;
      palette_colors[slot] = color;
      low_x[slot]          = column;
      low_y[slot]          = row;
      high_x[slot]         = column;
      high_y[slot]         = row;
      palette_used++;
      r.fresh = 1'b1;
      hit     = 1'b1;
    end else begin
      r.full = 1'b1;
    end
    if (hit) begin
      r.index = 8'(slot);
      r.min_x = low_x[slot];
      r.min_y = low_y[slot];
      r.max_x = high_x[slot];
      r.max_y = high_y[slot];
    end
    // width 0 acts as 1, widths past 4096 act as 4096
    if (row_width == '0) span = 13'd1;
    else if (row_width > 13'd4096) span = 13'd4096;
    else span = row_width;
    next_col = {1'b0, column} + 13'd1;
    if (next_col >= span) begin
      column = '0;
      row    = row + 12'd1;
    end else begin
      column = next_col[11:0];
    end
    return r;
  endfunction

  task automatic check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 checked, label, want_v, got_v);
    end
  endtask

  // follow config writes and pixel transfers, compare result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      palette_used   = 0;
      column         = '0;
      row            = '0;
      row_width      = WidthReset;
      queued_pixel_results.delete();
      mismatches     = 0;
      pending        = 0;
      checked        = 0;
      fresh_entries  = 0;
      overflows      = 0;
      widths_written = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width = cfg_data;
        widths_written++;
      end
      if (in_tvalid && in_tready)
        queued_pixel_results.push_back(classify_pixel(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got.index = out_tdata[7:0];
        got.min_x = out_tdata[19:8];
        got.min_y = out_tdata[31:20];
        got.max_x = out_tdata[43:32];
        got.max_y = out_tdata[55:44];
        got.fresh = out_tuser[0];
        got.full  = out_tuser[1];
        if (queued_pixel_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result transfer with no pixel pending: tdata %0h tuser %0h",
                     out_tdata, out_tuser);
        end else begin
          want = queued_pixel_results.pop_front();
          check_field("palette_index", 32'(want.index), 32'(got.index));
          check_field("is_new_color", 32'(want.fresh), 32'(got.fresh));
          check_field("palette_overflow", 32'(want.full), 32'(got.full));
          check_field("box_min_x", 32'(want.min_x), 32'(got.min_x));
          check_field("box_min_y", 32'(want.min_y), 32'(got.min_y));
          check_field("box_max_x", 32'(want.max_x), 32'(got.max_x));
          check_field("box_max_y", 32'(want.max_y), 32'(got.max_y));
          if (want.fresh) fresh_entries++;
          if (want.full) overflows++;
          checked++;
        end
      end
      pending = queued_pixel_results.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned DrainCycles  = 300;  // row of 256 cells plus margin
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned RandomPixels = 400;
  localparam int unsigned PoolMax      = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data   = '0;

  int mismatches;
  int pending;
  int checked;
  int fresh_entries;
  int overflows;
  int widths_written;

  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned idle_pct     = 0;
  int unsigned cycles       = 0;
  int unsigned frames_started = 0;
  logic [31:0] color_pool [PoolMax];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  palette_index_with_bounding_boxes_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pibb_checker palette_watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .checked        (checked),
    .fresh_entries  (fresh_entries),
    .overflows      (overflows),
    .widths_written (widths_written)
  );

  // offer one pixel, maybe after an idle burst, and wait for its transfer
  task automatic offer_pixel(logic [31:0] color, logic start);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= color;
    in_tuser  <= start;
    if (start) frames_started++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drain the block, then write the row width
  task automatic set_width(logic [12:0] w);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame drawn from a pool of distinct colors, with some wild colors
  // and some stray frame starts mixed in
  task automatic run_frame(int unsigned length, int unsigned colors,
                           int unsigned wild_pct, int unsigned break_pct);
    logic [31:0] mask;
    logic [31:0] color;
    logic        start;
    int unsigned k;
    mask = $urandom();
    for (k = 0; k < colors; k++)
      color_pool[k] = ((k << 23) | ($urandom() & 32'h007F_FFFF)) ^ mask;
    for (k = 0; k < length; k++) begin
      start = (k == 0) || ($urandom_range(99) < break_pct);
      if ($urandom_range(99) < wild_pct) color = $urandom();
      else color = color_pool[$urandom_range(0, colors - 1)];
      offer_pixel(color, start);
    end
  endtask

  // one frame of all-distinct colors, then two repeats of early colors
  task automatic run_distinct(int unsigned length);
    logic [31:0] mask;
    int unsigned k;
    mask = $urandom();
    for (k = 0; k < length; k++)
      offer_pixel(k ^ mask, k == 0);
    offer_pixel(mask, 1'b0);
    offer_pixel(32'd7 ^ mask, 1'b0);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned stall_pct;
    bit          held;
    stall_pct = 20;
    held      = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
      end else if (!calm && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(299) == 0) begin
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("run limit of %0d cycles reached", CycleLimit);
    $display("[palette_index_with_bounding_boxes_core] ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned random_sent;
    int unsigned phase;
    int unsigned len;
    logic [12:0] w;
    random_sent = 0;
    phase       = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero and all-one colors, hits, a mid-stream frame start
    idle_pct = 30;
    offer_pixel(32'h0000_0000, 1'b0);
    offer_pixel(32'hFFFF_FFFF, 1'b0);
    offer_pixel(32'h0000_0000, 1'b0);
    offer_pixel(32'h8000_0001, 1'b0);
    offer_pixel(32'h7FFF_FFFE, 1'b0);
    offer_pixel(32'hFFFF_FFFF, 1'b1);
    offer_pixel(32'hFFFF_FFFF, 1'b0);
    offer_pixel(32'h0000_0000, 1'b0);
    // one pixel per row
    set_width(13'd1);
    offer_pixel(32'hA5A5_5A5A, 1'b1);
    offer_pixel(32'h5A5A_A5A5, 1'b0);
    offer_pixel(32'hA5A5_5A5A, 1'b0);
    // width zero acts as one
    set_width(13'd0);
    offer_pixel(32'h1234_5678, 1'b1);
    offer_pixel(32'h1234_5678, 1'b0);
    offer_pixel(32'h8765_4321, 1'b0);
    // widest setting clamps to 4096
    set_width(13'h1FFF);
    offer_pixel(32'h0F0F_0F0F, 1'b1);
    offer_pixel(32'hF0F0_F0F0, 1'b0);
    // narrow rows, box grows in both directions
    set_width(13'd3);
    offer_pixel(32'hCAFE_0001, 1'b1);
    offer_pixel(32'hCAFE_0002, 1'b0);
    offer_pixel(32'hCAFE_0003, 1'b0);
    offer_pixel(32'hCAFE_0003, 1'b0);
    offer_pixel(32'hCAFE_0001, 1'b0);
    offer_pixel(32'hCAFE_0002, 1'b0);

    // random phases of frames at assorted widths
    while (random_sent < RandomPixels) begin
      case ($urandom_range(6))
        0:       w = 13'd0;
        1:       w = 13'd1;
        2:       w = 13'h1FFF;
        3:       w = 13'd4096;
        4:       w = 13'($urandom_range(2, 16));
        5:       w = 13'($urandom_range(1, 4096));
        default: w = 13'($urandom());
      endcase
      set_width(w);
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (phase == 1) begin
        // receiver holds off while distinct pixels keep coming: the row
        // fills up and the palette overflows
        hold_request <= 1'b1;
        idle_pct = 0;
        run_distinct(280);
        random_sent += 282;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          len = $urandom_range(1, 60);
          run_frame(len, $urandom_range(1, 12), 10, 5);
          random_sent += len;
        end
      end
      phase++;
    end

    // closing stretch with no idling on either side
    calm <= 1'b1;
    idle_pct = 0;
    set_width(13'($urandom_range(2, 40)));
    run_frame(40, 8, 10, 5);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("covered %0d pixels in %0d frames under %0d width settings",
             checked, frames_started, widths_written);
    $display("%0d new palette entries, %0d overflow results, one long output hold-off",
             fresh_entries, overflows);
    if (mismatches == 0) begin
      $display("[palette_index_with_bounding_boxes_core] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[palette_index_with_bounding_boxes_core] ERROR");
    end
    $finish;
  end

endmodule

// File: palette_index_with_bounding_boxes_core.f
sv/pibb_pkg.sv
sv/pibb_cell.sv
sv/pibb_coord.sv
sv/palette_index_with_bounding_boxes_core.sv
tb/pibb_checker.sv
tb/testbench.sv
